[rtl/blr_pkg.sv]
// Shared types and constants of the bandwidth and latency limiter.
`timescale 1ns / 1ps

package blr_pkg;

  // Width of the channel next-free cycle counters (range 32 to 64).
  localparam int CycleWidth = 48;

  localparam int NowW  = 48;
  localparam int SizeW = 16;
  localparam int LatW  = 32;
  localparam int DurW  = 16;
  localparam int BpcW  = 13;
  localparam int FixW  = 16;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegBytesPerCycle = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFixedLatency  = 1'd1;

  // Slave tdata layout from the lowest bit up.
  localparam int NowLsb   = 0;
  localparam int SizeLsb  = NowLsb + NowW;
  localparam int LatLsb   = SizeLsb + SizeW;
  localparam int DurLsb   = LatLsb + LatW;
  localparam int SDataW   = ((DurLsb + DurW + 7) / 8) * 8;

  // Master tdata layout from the lowest bit up.
  localparam int MDataW   = ((LatW + DurW + 7) / 8) * 8;

  // One quotient bit per divider step.
  localparam int DivSteps = SizeW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic load;
    logic div_step;
    logic calc;
    logic finish;
  } blr_cmd_t;

  typedef struct packed {
    logic bpc_zero;
  } blr_sts_t;

endpackage

[rtl/blr_datapath.sv]
// Datapath of the limiter: configuration, request registers, divider and channel state.
`timescale 1ns / 1ps

module blr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [blr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [blr_pkg::SDataW-1:0]    s_tdata_i,
  input  logic                          s_tuser_i,
  input  blr_pkg::blr_cmd_t             cmd_i,
  output blr_pkg::blr_sts_t             sts_o,
  output logic [blr_pkg::MDataW-1:0]    m_tdata_o
);

  localparam int CycW = blr_pkg::CycleWidth;
  localparam logic [63:0] CycMax64 = (64'd1 << CycW) - 64'd1;

  logic [blr_pkg::BpcW-1:0]  bpc_q;
  logic [blr_pkg::FixW-1:0]  fix_q;
  logic [CycW-1:0]           rd_free_q, rd_free_d;
  logic [CycW-1:0]           wr_free_q, wr_free_d;

  logic [CycW-1:0]           now_q;
  logic                      wr_q;
  logic [blr_pkg::LatW-1:0]  lat_q;
  logic [blr_pkg::DurW-1:0]  dur_q;
  logic [blr_pkg::SizeW-1:0] quot_q;
  logic [blr_pkg::BpcW-1:0]  rem_q;
  logic [blr_pkg::SizeW-1:0] burst_q;
  logic [CycW-1:0]           wait_q;
  logic [CycW-1:0]           start_q;
  logic [blr_pkg::LatW-1:0]  lat_out_q;
  logic [blr_pkg::DurW-1:0]  dur_out_q;

  logic [63:0]               now_ext;
  logic [CycW-1:0]           now_clamped;
  logic [blr_pkg::BpcW:0]    trial;
  logic [blr_pkg::BpcW:0]    divisor;
  logic                      q_bit;
  logic [blr_pkg::BpcW-1:0]  rem_next;
  logic [blr_pkg::SizeW-1:0] burst;
  logic [CycW-1:0]           chan_free;
  logic                      chan_busy;
  logic [CycW-1:0]           lat_ext;
  logic [CycW-1:0]           lat_max;
  logic [CycW:0]             lat_sum;
  logic [blr_pkg::LatW-1:0]  lat_sat;
  logic [CycW:0]             free_sum;
  logic [CycW-1:0]           free_sat;

  assign sts_o.bpc_zero = (bpc_q == '0);

  // Stamps beyond the counter range are clamped to its maximum.
  assign now_ext     = 64'(s_tdata_i[blr_pkg::NowLsb +: blr_pkg::NowW]);
  assign now_clamped = (now_ext > CycMax64) ? CycMax64[CycW-1:0] : now_ext[CycW-1:0];

  // Restoring division step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem_q, quot_q[blr_pkg::SizeW-1]};
  assign divisor  = {1'b0, bpc_q};
  assign q_bit    = (trial >= divisor);
  assign rem_next = q_bit ? blr_pkg::BpcW'(trial - divisor) : trial[blr_pkg::BpcW-1:0];

  // Round the quotient up when a remainder is left.
  assign burst     = quot_q + blr_pkg::SizeW'(rem_q != '0);
  assign chan_free = wr_q ? wr_free_q : rd_free_q;
  assign chan_busy = (chan_free > now_q);

  assign lat_ext  = CycW'(lat_q);
  assign lat_max  = (!sts_o.bpc_zero && (wait_q > lat_ext)) ? wait_q : lat_ext;
  assign lat_sum  = {1'b0, lat_max} + (CycW + 1)'(fix_q);
  assign lat_sat  = (lat_sum > (CycW + 1)'({blr_pkg::LatW{1'b1}})) ?
                    {blr_pkg::LatW{1'b1}} : lat_sum[blr_pkg::LatW-1:0];

  assign free_sum = {1'b0, start_q} + (CycW + 1)'(burst_q);
  assign free_sat = free_sum[CycW] ? {CycW{1'b1}} : free_sum[CycW-1:0];

  always_comb begin
    rd_free_d = rd_free_q;
    wr_free_d = wr_free_q;
    if (cmd_i.finish && !sts_o.bpc_zero) begin
      if (wr_q) begin
        wr_free_d = free_sat;
      end else begin
        rd_free_d = free_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q     <= '0;
      fix_q     <= '0;
      rd_free_q <= '0;
      wr_free_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          blr_pkg::RegBytesPerCycle: bpc_q <= cfg_data_i[blr_pkg::BpcW-1:0];
          blr_pkg::RegFixedLatency:  fix_q <= cfg_data_i[blr_pkg::FixW-1:0];
          default: ;
        endcase
      end
      rd_free_q <= rd_free_d;
      wr_free_q <= wr_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= now_clamped;
      wr_q   <= s_tuser_i;
      lat_q  <= s_tdata_i[blr_pkg::LatLsb +: blr_pkg::LatW];
      dur_q  <= s_tdata_i[blr_pkg::DurLsb +: blr_pkg::DurW];
      quot_q <= s_tdata_i[blr_pkg::SizeLsb +: blr_pkg::SizeW];
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      quot_q <= {quot_q[blr_pkg::SizeW-2:0], q_bit};
      rem_q  <= rem_next;
    end
    if (cmd_i.calc) begin
      burst_q <= burst;
      if (burst > dur_q) begin
        dur_q <= burst;
      end
      wait_q  <= chan_busy ? (chan_free - now_q) : '0;
      start_q <= chan_busy ? chan_free : now_q;
    end
    if (cmd_i.finish) begin
      lat_out_q <= lat_sat;
      dur_out_q <= dur_q;
    end
  end

  assign m_tdata_o = blr_pkg::MDataW'({dur_out_q, lat_out_q});

endmodule

[rtl/blr_ctrl.sv]
// Controller of the limiter: sequences load, division, channel update and result hand-off.
`timescale 1ns / 1ps

module blr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  blr_pkg::blr_sts_t sts_i,
  output blr_pkg::blr_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StCalc,
    StFinish
  } state_e;

  state_e                        state_q, state_d;
  logic [blr_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.bpc_zero ? StFinish : StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == blr_pkg::DivCntW'(blr_pkg::DivSteps - 1)) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StFinish;
      end
      StFinish: begin
        // The result register is refilled only once its previous item is gone.
        if (!out_valid_q || m_tready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/bandwidth_latency_limiter.sv]
// Top level of the bandwidth and latency limiter for memory requests.
//
// Channel   Dir  Payload
// s_axis    in   tdata: now_cycle, byte_count, latency_in, duration_in; tuser: write select
// m_axis    out  tdata: latency_out, duration_out
// cfg       in   register write: 0 bytes_per_cycle, 1 fixed_latency
//
// With a bandwidth set, an item is loaded, passes 16 steps of the radix-2 divider
// that forms the burst time, is compared against the channel's next free cycle and
// has its result register written; with zero bandwidth the load leads straight to
// that write. One item is in work at a time; the finished result waits in
// the output register while the next item is taken in, and only the final write
// stalls on m_axis_tready. Reset clears configuration and both channel counters.
`timescale 1ns / 1ps

module bandwidth_latency_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [blr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_cycle [47:0], byte_count [63:48], latency_in [95:64], duration_in [111:96]
  input  logic [blr_pkg::SDataW-1:0]    s_axis_tdata,
  // write select [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // latency_out [31:0], duration_out [47:32]
  output logic [blr_pkg::MDataW-1:0]    m_axis_tdata
);

  blr_pkg::blr_cmd_t cmd;
  blr_pkg::blr_sts_t sts;

  blr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

[dv/tb_bandwidth_latency_limiter.sv]
// Self-checking testbench of the bandwidth and latency limiter.
`timescale 1ns / 1ps

module tb_bandwidth_latency_limiter;
  import blr_pkg::*;

  localparam int NumRows      = 25;
  localparam int NumPhases    = 8;
  localparam int RandPerPhase = 194;
  localparam int SettleCycles = 24;
  localparam int DrainCycles  = 40;
  localparam int MaxReports   = 10;
  localparam longint unsigned TimeoutNs = 64'd10_000_000;

  localparam logic [CycleWidth-1:0] CycMax = '1;
  localparam logic [LatW-1:0]       LatMax = '1;

  typedef struct packed {
    logic [LatW-1:0] latency;
    logic [DurW-1:0] duration;
  } grant_t;

  typedef enum logic {RowReq, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               tail;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [NowW-1:0]    now;
    logic [SizeW-1:0]   size;
    logic               wr;
    logic [LatW-1:0]    lat;
    logic [DurW-1:0]    dur;
    logic               typed;
    grant_t             t_res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // now_cycle, byte_count, latency_in, duration_in
  logic [SDataW-1:0]   s_axis_tdata;
  // write select
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // latency_out, duration_out
  logic [MDataW-1:0]   m_axis_tdata;

  bandwidth_latency_limiter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the limiter state and its registers.
  logic [BpcW-1:0]       bw_bytes;
  logic [FixW-1:0]       added_lat;
  logic [CycleWidth-1:0] rd_free;
  logic [CycleWidth-1:0] wr_free;

  grant_t   pending[$];
  dir_row_t dir_tab[NumRows];

  logic                  no_gaps = 1'b0;
  int                    stall_left = 0;
  logic [CycleWidth-1:0] stamp;
  int items_sent, results_seen, reg_writes, sat_cnt, backlog_cnt, fails;

  function automatic grant_t shape_request(input logic [NowW-1:0] now,
                                           input logic [SizeW-1:0] size,
                                           input logic wr,
                                           input logic [LatW-1:0] lat_in,
                                           input logic [DurW-1:0] dur_in);
    logic [CycleWidth-1:0] burst, wait_cyc, free_at, start, lat_w;
    logic [CycleWidth:0]   sum;
    grant_t                g;
    g.duration = dur_in;
    if (bw_bytes == '0) begin
      sum = lat_in + added_lat;
      g.latency = (sum > LatMax) ? LatMax : sum[LatW-1:0];
      return g;
    end
    burst = (size + bw_bytes - 1'b1) / bw_bytes;
    if (burst > dur_in) g.duration = burst[DurW-1:0];
    free_at  = wr ? wr_free : rd_free;
    wait_cyc = (free_at > now) ? free_at - now : '0;
    if (wait_cyc != '0) backlog_cnt++;
    lat_w = (wait_cyc > lat_in) ? wait_cyc : lat_in;
    sum = lat_w + added_lat;
    g.latency = (sum > LatMax) ? LatMax : sum[LatW-1:0];
    // The channel is booked from whichever is later, now or its next free cycle.
    start = (free_at > now) ? free_at : now;
    sum = start + burst;
    if (sum > CycMax) sum = CycMax;
    if (wr) wr_free = sum[CycleWidth-1:0];
    else rd_free = sum[CycleWidth-1:0];
    return g;
  endfunction

  function automatic int gap_len();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_row_t req_row(input logic tail, input logic [NowW-1:0] now,
                                       input logic [SizeW-1:0] size, input logic wr,
                                       input logic [LatW-1:0] lat, input logic [DurW-1:0] dur,
                                       input logic typed, input logic [LatW-1:0] t_lat,
                                       input logic [DurW-1:0] t_dur);
    dir_row_t row;
    row = '0;
    row.kind = RowReq;
    row.tail = tail;
    row.now = now;
    row.size = size;
    row.wr = wr;
    row.lat = lat;
    row.dur = dur;
    row.typed = typed;
    row.t_res.latency = t_lat;
    row.t_res.duration = t_dur;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic tail, input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = RowReg;
    row.tail = tail;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBytesPerCycle) bw_bytes = val[BpcW-1:0];
    else added_lat = val[FixW-1:0];
    reg_writes++;
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [NowW-1:0] now, input logic [SizeW-1:0] size,
                           input logic wr, input logic [LatW-1:0] lat,
                           input logic [DurW-1:0] dur, input logic use_typed,
                           input grant_t typed);
    logic [SDataW-1:0] word;
    grant_t            g;
    int                gap;
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    g = shape_request(now, size, wr, lat, dur);
    if (use_typed) g = typed;
    if (g.latency == LatMax) sat_cnt++;
    pending.insert(pending.size(), g);
    word = '0;
    word[NowLsb +: NowW]   = now;
    word[SizeLsb +: SizeW] = size;
    word[LatLsb +: LatW]   = lat;
    word[DurLsb +: DurW]   = dur;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= wr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic run_row(input dir_row_t row);
    if (row.kind == RowReg) begin
      drop_valid();
      wait_drained();
      write_reg(row.reg_idx, row.reg_val);
    end else begin
      send_item(row.now, row.size, row.wr, row.lat, row.dur, row.typed, row.t_res);
    end
  endtask

  // With limiting on, stamps mostly creep forward so that channels back up, with
  // rare jumps that free them and a few requests stamped in the past.
  task automatic send_random(input logic limiting);
    logic [NowW-1:0]  now;
    logic [SizeW-1:0] size;
    logic [LatW-1:0]  lat;
    logic [DurW-1:0]  dur;
    logic [CycleWidth-1:0] back;
    int               pick;
    if (!limiting) begin
      now[31:0]      = $urandom;
      now[NowW-1:32] = (NowW-32)'($urandom);
      size = SizeW'($urandom);
      lat  = $urandom;
      dur  = DurW'($urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) stamp += CycleWidth'($urandom_range(0, 8));
      else if (pick < 95) stamp += CycleWidth'($urandom_range(0, 300));
      else if (pick < 99) stamp += CycleWidth'($urandom_range(0, 100000));
      else stamp += CycleWidth'({8'($urandom_range(0, 255)), 32'($urandom)});
      now = stamp;
      if ($urandom_range(0, 19) == 0) begin
        back = CycleWidth'($urandom_range(1, 1000));
        now = (stamp > back) ? stamp - back : '0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) size = SizeW'($urandom_range(0, 4 * int'(bw_bytes)));
      else if (pick < 9) size = SizeW'($urandom_range(0, 255));
      else size = SizeW'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6) lat = $urandom_range(0, 20);
      else if (pick < 9) lat = $urandom_range(0, 1000);
      else lat = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 5) dur = '0;
      else if (pick < 8) dur = DurW'($urandom_range(0, 8));
      else dur = DurW'($urandom);
    end
    send_item(now, size, 1'($urandom_range(0, 1)), lat, dur, 1'b0, '0);
  endtask

  task automatic take_result(input logic [MDataW-1:0] word);
    grant_t exp_g;
    grant_t got;
    got.latency  = word[LatW-1:0];
    got.duration = word[LatW +: DurW];
    results_seen++;
    if (pending.size() == 0) begin
      fails++;
      if (fails <= MaxReports)
        $display("Result %0d arrived with nothing expected: latency %h duration %h",
                 results_seen, got.latency, got.duration);
      return;
    end
    exp_g = pending.pop_front();
    if (got !== exp_g) begin
      fails++;
      if (fails <= MaxReports)
        $display("Result %0d: latency expected %h got %h, duration expected %h got %h",
                 results_seen, exp_g.latency, got.latency, exp_g.duration, got.duration);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) take_result(m_axis_tdata);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] bw_val;
    logic [CfgDataW-1:0] fix_val;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    rst_ni        <= 1'b0;
    bw_bytes  = '0;
    added_lat = '0;
    rd_free   = '0;
    wr_free   = '0;
    items_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    sat_cnt = 0;
    backlog_cnt = 0;
    fails = 0;

    // Bypass with nothing added, then with the largest fixed latency.
    dir_tab[0]  = req_row(0, 48'd0, 16'd0, 1'b0, 32'd0, 16'd0, 1, 32'd0, 16'd0);
    dir_tab[1]  = req_row(0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
                          1, 32'hFFFF_FFFF, 16'hFFFF);
    dir_tab[2]  = reg_row(0, RegFixedLatency, 16'hFFFF);
    dir_tab[3]  = req_row(0, 48'd5, 16'd10, 1'b0, 32'hFFFF_FFF0, 16'h1234,
                          1, 32'hFFFF_FFFF, 16'h1234);
    dir_tab[4]  = req_row(0, 48'd6, 16'd0, 1'b1, 32'd5, 16'd0, 1, 32'h1_0004, 16'd0);
    dir_tab[5]  = reg_row(0, RegFixedLatency, 16'd0);
    // One byte per cycle: burst time equals the size.
    dir_tab[6]  = reg_row(0, RegBytesPerCycle, 16'd1);
    dir_tab[7]  = req_row(0, 48'd100, 16'd16, 1'b0, 32'd0, 16'd0, 1, 32'd0, 16'd16);
    dir_tab[8]  = req_row(0, 48'd104, 16'd4, 1'b0, 32'd0, 16'd0, 1, 32'd12, 16'd4);
    dir_tab[9]  = req_row(0, 48'd104, 16'd0, 1'b1, 32'd3, 16'd7, 1, 32'd3, 16'd7);
    dir_tab[10] = req_row(0, 48'd200, 16'd1, 1'b0, 32'd1, 16'd0, 1, 32'd1, 16'd1);
    dir_tab[11] = req_row(0, 48'd0, 16'hFFFF, 1'b1, 32'd0, 16'd0, 1, 32'd104, 16'hFFFF);
    // Stamp equal to the write channel's next free cycle.
    dir_tab[12] = req_row(0, 48'd65639, 16'd2, 1'b1, 32'd0, 16'd5, 1, 32'd0, 16'd5);
    // Bandwidth beyond its nominal range, upper data bits set.
    dir_tab[13] = reg_row(0, RegBytesPerCycle, 16'hFFFF);
    dir_tab[14] = req_row(0, 48'd300, 16'hFFFF, 1'b0, 32'd0, 16'd0, 0, 32'd0, 16'd0);
    dir_tab[15] = req_row(0, 48'd300, 16'd8191, 1'b0, 32'd0, 16'd0, 0, 32'd0, 16'd0);
    dir_tab[16] = reg_row(0, RegBytesPerCycle, 16'd4096);
    dir_tab[17] = req_row(0, 48'd1000, 16'd4097, 1'b1, 32'd0, 16'd0, 0, 32'd0, 16'd0);
    dir_tab[18] = req_row(0, 48'd70000, 16'd4096, 1'b1, 32'd0, 16'hFFFF, 0, 32'd0, 16'd0);
    // Saturation of the next-free counters; run last since it pins the channels.
    dir_tab[19] = reg_row(1, RegBytesPerCycle, 16'd1);
    dir_tab[20] = reg_row(1, RegFixedLatency, 16'h0010);
    dir_tab[21] = req_row(1, 48'hFFFF_FFFF_FFF0, 16'hFFFF, 1'b0, 32'd0, 16'd0,
                          0, 32'd0, 16'd0);
    dir_tab[22] = req_row(1, 48'd0, 16'd8, 1'b0, 32'd0, 16'd0, 0, 32'd0, 16'd0);
    dir_tab[23] = req_row(1, 48'hFFFF_FFFF_FFFF, 16'd1, 1'b0, 32'd7, 16'd0, 0, 32'd0, 16'd0);
    dir_tab[24] = req_row(1, 48'hFFFF_FFFF_FFFE, 16'd3, 1'b1, 32'd0, 16'd0, 0, 32'd0, 16'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++)
      if (!dir_tab[r].tail) run_row(dir_tab[r]);

    stamp = CycleWidth'(100000);
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: begin
          bw_val  = '0;
          fix_val = CfgDataW'($urandom);
        end
        2: begin
          bw_val  = CfgDataW'($urandom_range(2, 16));
          fix_val = CfgDataW'($urandom_range(0, 50));
        end
        3: begin
          bw_val  = CfgDataW'(64);
          fix_val = '1;
        end
        4: begin
          bw_val  = {3'($urandom_range(0, 7)), 13'($urandom_range(4097, 8191))};
          fix_val = CfgDataW'($urandom);
        end
        5: begin
          bw_val  = CfgDataW'(4096);
          fix_val = CfgDataW'(1);
        end
        6: begin
          bw_val  = CfgDataW'($urandom_range(1, 4096));
          fix_val = CfgDataW'($urandom);
        end
        7: begin
          bw_val  = '0;
          fix_val = '1;
        end
        default: begin
          bw_val  = CfgDataW'(1);
          fix_val = '0;
        end
      endcase
      drop_valid();
      wait_drained();
      write_reg(RegBytesPerCycle, bw_val);
      write_reg(RegFixedLatency, fix_val);
      for (int n = 0; n < RandPerPhase; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random(bw_val[BpcW-1:0] != '0);
      end
    end

    no_gaps = 1'b0;
    for (int r = 0; r < NumRows; r++)
      if (dir_tab[r].tail) run_row(dir_tab[r]);

    drop_valid();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests and %0d results across %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("%0d requests waited on a busy channel, %0d latencies saturated.",
             backlog_cnt, sat_cnt);
    if (fails == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
